>>> hw/rtl/lzhw_pkg.sv
// lzhw_pkg: shared constants, command and state types of the history window
// no dependencies; imported by the top level, lzhw_front and lzhw_back
`timescale 1ns / 1ps

package lzhw_pkg;

  // window size, a power of two from 256 to 65536
  localparam int unsigned WINDOW_BYTES = 32768;
  localparam int unsigned AW           = $clog2(WINDOW_BYTES);
  localparam int unsigned FW           = AW + 1;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned DIST_W       = 16;
  localparam int unsigned LEN_W        = 9;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned QDEPTH       = 2;

  localparam logic [ACT_W-1:0] ACT_PUT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COPY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_COPY,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_COPY
  } back_state_e;

  typedef logic [AW-1:0] ptr_t;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] lit;
    ptr_t              distance;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

>>> hw/rtl/lz77_history_window.sv
// lz77_history_window: output history window of an inflate decoder, top level
// depends on lzhw_pkg, lzhw_front, lzhw_back (which holds lzhw_ram)
//
//   port group        dir  signals                                      handshake
//   request           in   action_i in_byte_i copy_distance_i           start & !busy
//                          copy_length_i
//   result            out  out_byte_o count_o                           done_o, one cycle
//
// requests enter a two-entry queue at one per cycle until it is full (busy).
// the executer takes one request at a time: put, no-op and an empty copy are done
// in the idle state, a read waits for the registered ram read, and a copy decodes,
// then writes one window byte per cycle through the single ram write port behind
// a registered ram read; done_o is registered.
// after reset the positions and fill count are zero; window contents are
// undefined until written, no clearing pass. results cannot be held off.
`timescale 1ns / 1ps

module lz77_history_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [lzhw_pkg::ACT_W-1:0]  action_i,
  input  logic [lzhw_pkg::BYTE_W-1:0] in_byte_i,
  input  logic [lzhw_pkg::DIST_W-1:0] copy_distance_i,
  input  logic [lzhw_pkg::LEN_W-1:0]  copy_length_i,
  output logic                        done_o,
  output logic [lzhw_pkg::BYTE_W-1:0] out_byte_o,
  output logic [lzhw_pkg::LEN_W-1:0]  count_o
);
  import lzhw_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  lzhw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .action_i        (action_i),
    .in_byte_i       (in_byte_i),
    .copy_distance_i (copy_distance_i),
    .copy_length_i   (copy_length_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .pop_i           (pop)
  );

  lzhw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .done_o      (done_o),
    .out_byte_o  (out_byte_o),
    .count_o     (count_o)
  );

endmodule

>>> hw/rtl/lzhw_ram.sv
// lzhw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lzhw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lzhw_front.sv
// lzhw_front: takes commands, decodes the action, reduces the copy distance
// and holds them in a two-entry queue for the back end; uses lzhw_pkg
`timescale 1ns / 1ps

module lzhw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [lzhw_pkg::ACT_W-1:0]    action_i,
  input  logic [lzhw_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic [lzhw_pkg::DIST_W-1:0]   copy_distance_i,
  input  logic [lzhw_pkg::LEN_W-1:0]    copy_length_i,
  output logic                          cmd_valid_o,
  output lzhw_pkg::cmd_t                cmd_o,
  input  logic                          pop_i
);
  import lzhw_pkg::*;

  cmd_t       q_mem [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.lit      = in_byte_i;
    // power-of-two window: the modulo is the low bits
    cmd_in.distance = copy_distance_i[AW-1:0];
    cmd_in.len      = copy_length_i;
    unique case (action_i)
      ACT_PUT:  cmd_in.op = OP_PUT;
      ACT_COPY: cmd_in.op = OP_COPY;
      ACT_READ: cmd_in.op = OP_READ;
      ACT_NOP:  cmd_in.op = OP_NOP;
      default:  cmd_in.op = OP_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == 2'(QDEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/lzhw_back.sv
// lzhw_back: executes queued commands against the window ram and keeps the
// write and read positions and the fill count; uses lzhw_pkg and lzhw_ram
`timescale 1ns / 1ps

module lzhw_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  lzhw_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic [lzhw_pkg::BYTE_W-1:0] out_byte_o,
  output logic [lzhw_pkg::LEN_W-1:0]  count_o
);
  import lzhw_pkg::*;

  back_state_e       state_q, state_d;
  ptr_t              wp_q, wp_d;
  ptr_t              rp_q, rp_d;
  logic [FW-1:0]     fill_q, fill_d;
  ptr_t              src_q, src_d;
  logic [LEN_W-1:0]  rd_left_q, rd_left_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic              pend_q, pend_d;
  logic              byp_q, byp_d;
  logic [BYTE_W-1:0] lastw_q, lastw_d;
  logic              res_valid_q, res_valid_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;
  logic [LEN_W-1:0]  res_cnt_q, res_cnt_d;

  logic              ram_we;
  ptr_t              ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  ptr_t              ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [FW-1:0]     space;
  logic [LEN_W-1:0]  copy_n;
  logic [BYTE_W-1:0] copy_byte;
  logic              cp_rd;
  logic              cp_wr;

  lzhw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_BYTES)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign space     = FW'(WINDOW_BYTES) - fill_q;
  assign copy_n    = (FW'(cmd_i.len) < space) ? cmd_i.len : space[LEN_W-1:0];
  // a read that hit the address written in the same cycle returns stale data
  assign copy_byte = byp_q ? lastw_q : ram_rdata;
  assign cp_rd     = (rd_left_q != '0);
  assign cp_wr     = pend_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    src_d       = src_q;
    rd_left_d   = rd_left_q;
    n_d         = n_q;
    pend_d      = 1'b0;
    byp_d       = 1'b0;
    lastw_d     = lastw_q;
    res_valid_d = 1'b0;
    res_byte_d  = '0;
    res_cnt_d   = '0;
    ram_we      = 1'b0;
    ram_waddr   = wp_q;
    ram_wdata   = cmd_i.lit;
    ram_re      = 1'b0;
    ram_raddr   = rp_q;
    pop_o       = 1'b0;

    unique case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUT: begin
              res_valid_d = 1'b1;
              if (fill_q < FW'(WINDOW_BYTES)) begin
                ram_we    = 1'b1;
                wp_d      = wp_q + 1'b1;
                fill_d    = fill_q + 1'b1;
                res_cnt_d = LEN_W'(1);
              end
            end
            OP_READ: begin
              if (fill_q != '0) begin
                ram_re  = 1'b1;
                state_d = BS_READ;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            OP_COPY: begin
              if (copy_n == '0) begin
                res_valid_d = 1'b1;
              end else begin
                n_d       = copy_n;
                rd_left_d = copy_n;
                src_d     = wp_q - cmd_i.distance;
                state_d   = BS_COPY;
              end
            end
            OP_NOP: begin
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      BS_READ: begin
        res_valid_d = 1'b1;
        res_byte_d  = ram_rdata;
        res_cnt_d   = LEN_W'(1);
        rp_d        = rp_q + 1'b1;
        fill_d      = fill_q - 1'b1;
        state_d     = BS_IDLE;
      end

      BS_COPY: begin
        // read of byte k overlaps the write of byte k-1
        if (cp_wr) begin
          ram_we    = 1'b1;
          ram_waddr = wp_q;
          ram_wdata = copy_byte;
          wp_d      = wp_q + 1'b1;
          fill_d    = fill_q + 1'b1;
          lastw_d   = copy_byte;
        end
        if (cp_rd) begin
          ram_re    = 1'b1;
          ram_raddr = src_q;
          src_d     = src_q + 1'b1;
          rd_left_d = rd_left_q - 1'b1;
        end
        pend_d = cp_rd;
        byp_d  = cp_rd && cp_wr && (src_q == wp_q);
        if (cp_wr && !cp_rd) begin
          res_valid_d = 1'b1;
          res_cnt_d   = n_q;
          state_d     = BS_IDLE;
        end
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      byp_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      byp_q       <= byp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    n_q        <= n_d;
    lastw_q    <= lastw_d;
    res_byte_q <= res_byte_d;
    res_cnt_q  <= res_cnt_d;
  end

  assign done_o     = res_valid_q;
  assign out_byte_o = res_byte_q;
  assign count_o    = res_cnt_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_BYTES))
    else $error("fill count above window size");

  a_fill_matches_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_t'(wp_q - rp_q) == fill_q[AW-1:0])
    else $error("positions disagree with fill count");

  a_copy_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_COPY) |-> (cp_rd || cp_wr))
    else $error("copy state with nothing left to do");

  a_read_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_READ) |=> (res_valid_q && res_cnt_q == LEN_W'(1)))
    else $error("read did not return its byte");

  a_no_pop_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BS_IDLE))
    else $error("request taken while a command is in progress");

endmodule
